@@ rtl/npsched_pkg.sv @@
// Shared types and constants for the non-preemptive priority scheduler.
`default_nettype none
package npsched_pkg;

  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 22;
  localparam int IDX_W   = 5;
  localparam int IDX_LIMIT = 32;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               done;
  } rec_t;

  typedef struct packed {
    logic               rdy_found;
    logic [ARR_W-1:0]   rdy_arr;
    logic [BURST_W-1:0] rdy_burst;
    logic [PRIO_W-1:0]  rdy_prio;
    logic               pend_found;
    logic [ARR_W-1:0]   pend_arr;
    logic [BURST_W-1:0] pend_burst;
    logic [PRIO_W-1:0]  pend_prio;
  } pick_t;

endpackage
`default_nettype wire

@@ rtl/npsched_cell.sv @@
// One cell of the process ring: holds a record and passes it to its neighbor.
`default_nettype none
module npsched_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               shift,
  input  wire npsched_pkg::rec_t  din,
  input  wire logic               set_done,
  input  wire logic               clr_done,
  output npsched_pkg::rec_t       dout
);

  logic [npsched_pkg::ARR_W-1:0]   arrival;
  logic [npsched_pkg::BURST_W-1:0] burst;
  logic [npsched_pkg::PRIO_W-1:0]  prio;
  logic                            done;

  always_ff @(posedge clk) begin
    if (shift) begin
      arrival <= din.arrival;
      burst   <= din.burst;
      prio    <= din.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (shift) begin
      done <= din.done;
    end else if (clr_done) begin
      done <= 1'b0;
    end else if (set_done) begin
      done <= 1'b1;
    end
  end

  assign dout.arrival = arrival;
  assign dout.burst   = burst;
  assign dout.prio    = prio;
  assign dout.done    = done;

endmodule
`default_nettype wire

@@ rtl/npsched_pick.sv @@
// Selection unit: watches one ring cell per cycle while step is high and keeps the best candidates.
`default_nettype none
module npsched_pick #(
  parameter int POS_W = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           clr,
  input  wire logic                           step,
  input  wire logic                           occupied,
  input  wire npsched_pkg::rec_t              sample,
  input  wire logic [POS_W-1:0]               pos,
  input  wire logic [npsched_pkg::TIME_W-1:0] clock_now,
  output npsched_pkg::pick_t                  pk,
  output logic [POS_W-1:0]                    rdy_pos,
  output logic [POS_W-1:0]                    pend_pos
);

  logic live;
  logic is_ready;
  logic take_rdy;
  logic take_pend;

  assign live     = step && occupied && !sample.done;
  assign is_ready = npsched_pkg::TIME_W'(sample.arrival) <= clock_now;
  assign take_rdy = live && is_ready && (!pk.rdy_found || sample.prio < pk.rdy_prio);
  assign take_pend = live && (!pk.pend_found || sample.arrival < pk.pend_arr ||
                     (sample.arrival == pk.pend_arr && sample.prio < pk.pend_prio));

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      pk.rdy_found  <= 1'b0;
      pk.pend_found <= 1'b0;
    end else begin
      if (take_rdy) begin
        pk.rdy_found <= 1'b1;
      end
      if (take_pend) begin
        pk.pend_found <= 1'b1;
      end
    end
    if (take_rdy) begin
      pk.rdy_arr   <= sample.arrival;
      pk.rdy_burst <= sample.burst;
      pk.rdy_prio  <= sample.prio;
      rdy_pos      <= pos;
    end
    if (take_pend) begin
      pk.pend_arr   <= sample.arrival;
      pk.pend_burst <= sample.burst;
      pk.pend_prio  <= sample.prio;
      pend_pos      <= pos;
    end
  end

endmodule
`default_nettype wire

@@ rtl/nonpreemptive_priority_scheduler_core.sv @@
// Top level of the non-preemptive priority scheduler: ring of cells, selector and control.
//
// Input channel: one beat per process record (arrival, burst, prio, last).
// Records are taken one per cycle while the block is loading. A record that
// arrives when the store already holds its capacity is dropped. The beat with
// last set closes the set and starts the schedule at time zero.
// Output channel: one beat per scheduled process in schedule order, with
// final_res set on the last one of the set.
// For each result, where CAP is the smaller of MAX_PROCS and 32, the record
// ring rotates once past the selector, one cell per cycle, and the PUT state
// then commits the pick. No record is taken while a schedule runs.
// When the receiver stalls, the result holds in the output register and the
// next selection stops before its commit until the register is free.
// Reset clears the done flags, the record count, the time and all valid state.
`default_nettype none
module nonpreemptive_priority_scheduler_core #(
  parameter int MAX_PROCS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [npsched_pkg::ARR_W-1:0]       arrival,
  input  wire logic [npsched_pkg::BURST_W-1:0]     burst,
  input  wire logic [npsched_pkg::PRIO_W-1:0]      prio,
  input  wire logic                                last,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [npsched_pkg::IDX_W-1:0]            proc_index,
  output logic [npsched_pkg::TIME_W-1:0]           start_at,
  output logic [npsched_pkg::TIME_W-1:0]           end_at,
  output logic [npsched_pkg::TIME_W-1:0]           wait_ticks,
  output logic [npsched_pkg::TIME_W-1:0]           turnaround_ticks,
  output logic                                     final_res
);

  localparam int CAP   = (MAX_PROCS < npsched_pkg::IDX_LIMIT) ? MAX_PROCS
                                                              : npsched_pkg::IDX_LIMIT;
  localparam int POS_W = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int TW    = npsched_pkg::TIME_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_PUT  = 3'b100
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       loaded_count;
  logic [CNT_W-1:0]       sched_n;
  logic [POS_W-1:0]       scan_k;
  logic [TW-1:0]          clock_now;

  npsched_pkg::rec_t      chain [CAP];
  npsched_pkg::rec_t      new_rec;
  npsched_pkg::rec_t      tail_in;
  logic [CAP-1:0]         done_vec;
  logic [CAP-1:0]         set_done;

  npsched_pkg::pick_t     pk;
  logic [POS_W-1:0]       rdy_pos;
  logic [POS_W-1:0]       pend_pos;

  logic                   in_fire;
  logic                   load_fire;
  logic                   put_fire;
  logic                   last_put;
  logic                   shift;
  logic                   occupied;
  logic                   pick_clr;

  logic [POS_W-1:0]              sel_pos;
  logic [CNT_W-1:0]              sel_idx;
  logic [npsched_pkg::ARR_W-1:0] sel_arr;
  logic [npsched_pkg::BURST_W-1:0] sel_burst;
  logic [TW-1:0]                 sel_start;
  logic [TW-1:0]                 sel_end;

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign load_fire = in_fire && (loaded_count < CNT_W'(CAP));
  assign put_fire  = (state == S_PUT) && (!out_valid || !out_stall);
  assign last_put  = (sched_n == loaded_count - CNT_W'(1));
  assign shift     = load_fire || (state == S_SCAN);
  assign pick_clr  = (in_fire && last) || (put_fire && !last_put);
  assign occupied  = ((CNT_W + 1)'(scan_k) + (CNT_W + 1)'(loaded_count)) >=
                     (CNT_W + 1)'(CAP);

  assign new_rec.arrival = arrival;
  assign new_rec.burst   = burst;
  assign new_rec.prio    = prio;
  assign new_rec.done    = 1'b0;
  assign tail_in = (state == S_IDLE) ? new_rec : chain[0];

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    npsched_pkg::rec_t din;
    if (i == CAP - 1) begin : g_tail
      assign din = tail_in;
    end else begin : g_body
      assign din = chain[i+1];
    end
    assign set_done[i] = put_fire && !last_put && (sel_pos == POS_W'(i));
    assign done_vec[i] = chain[i].done;
    npsched_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .din      (din),
      .set_done (set_done[i]),
      .clr_done (put_fire && last_put),
      .dout     (chain[i])
    );
  end

  npsched_pick #(
    .POS_W (POS_W)
  ) u_pick (
    .clk       (clk),
    .rst       (rst),
    .clr       (pick_clr),
    .step      (state == S_SCAN),
    .occupied  (occupied),
    .sample    (chain[0]),
    .pos       (scan_k),
    .clock_now (clock_now),
    .pk        (pk),
    .rdy_pos   (rdy_pos),
    .pend_pos  (pend_pos)
  );

  assign sel_pos   = pk.rdy_found ? rdy_pos : pend_pos;
  assign sel_arr   = pk.rdy_found ? pk.rdy_arr : pk.pend_arr;
  assign sel_burst = pk.rdy_found ? pk.rdy_burst : pk.pend_burst;
  assign sel_start = pk.rdy_found ? clock_now : TW'(pk.pend_arr);
  assign sel_end   = sel_start + TW'(sel_burst);
  assign sel_idx   = CNT_W'(sel_pos) + loaded_count - CNT_W'(CAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded_count <= '0;
      sched_n      <= '0;
      scan_k       <= '0;
      clock_now    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (load_fire) begin
            loaded_count <= loaded_count + CNT_W'(1);
          end
          if (in_fire && last) begin
            state  <= S_SCAN;
            scan_k <= '0;
          end
        end
        S_SCAN: begin
          if (scan_k == POS_W'(CAP - 1)) begin
            scan_k <= '0;
            state  <= S_PUT;
          end else begin
            scan_k <= scan_k + POS_W'(1);
          end
        end
        S_PUT: begin
          if (put_fire) begin
            if (last_put) begin
              state        <= S_IDLE;
              loaded_count <= '0;
              sched_n      <= '0;
              clock_now    <= '0;
            end else begin
              state     <= S_SCAN;
              sched_n   <= sched_n + CNT_W'(1);
              clock_now <= sel_end;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_fire) begin
      proc_index       <= npsched_pkg::IDX_W'(sel_idx);
      start_at         <= sel_start;
      end_at           <= sel_end;
      wait_ticks       <= sel_start - TW'(sel_arr);
      turnaround_ticks <= sel_end - TW'(sel_arr);
      final_res        <= last_put;
    end
  end

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (loaded_count != '0))
    else $error("Schedule scan running over an empty record set.");

  a_commit_has_pick: assert property (@(posedge clk) disable iff (rst)
    put_fire |-> (pk.rdy_found || pk.pend_found))
    else $error("Commit without any unfinished process found.");

  a_idle_jump_forward: assert property (@(posedge clk) disable iff (rst)
    (put_fire && !pk.rdy_found) |-> (TW'(pk.pend_arr) > clock_now))
    else $error("Idle time jump does not move the clock forward.");

  a_done_marked: assert property (@(posedge clk) disable iff (rst)
    (put_fire && !last_put) |=> done_vec[$past(sel_pos)])
    else $error("Scheduled process not marked done.");

endmodule
`default_nettype wire
